// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, quiet while reset is low.
`define BMPFB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled signal keeps its value into the next cycle.
`define BMPFB_ASSERT_HOLD(lbl, clk, rst_n, stall, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (stall) |=> $stable(sig)) \
        else $error(msg);

`endif

// ===== sv/bmpfb_pkg.sv =====
// Types and constants of the BMP pixel streamer.
`timescale 1ns / 1ps
`default_nettype none

package bmpfb_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int SIDE_W     = 11;
    localparam int ORIGIN_W   = 10;
    localparam int PIX_ADDR_W = 19;
    localparam int COLOR_W    = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TOP_DOWN     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HAS_ALPHA    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd5;

    typedef struct packed {
        logic [SIDE_W-1:0]   image_width;
        logic [SIDE_W-1:0]   image_height;
        logic                top_down;
        logic                has_alpha;
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
    } cfg_t;

endpackage

`default_nettype wire

// ===== sv/bmpfb_cfg.sv =====
// APB register file holding the image geometry and format.
`timescale 1ns / 1ps
`default_nettype none

module bmpfb_cfg
    import bmpfb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  cfg_next.image_width  = pwdata[SIDE_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = pwdata[SIDE_W-1:0];
                REG_TOP_DOWN:     cfg_next.top_down     = pwdata[0];
                REG_HAS_ALPHA:    cfg_next.has_alpha    = pwdata[0];
                REG_ORIGIN_X:     cfg_next.origin_x     = pwdata[ORIGIN_W-1:0];
                REG_ORIGIN_Y:     cfg_next.origin_y     = pwdata[ORIGIN_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= SIDE_W'(1);
            cfg_reg.image_height <= SIDE_W'(1);
            cfg_reg.top_down     <= 1'b0;
            cfg_reg.has_alpha    <= 1'b0;
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(cfg_reg.image_height);
            REG_TOP_DOWN:     prdata = APB_DATA_W'(cfg_reg.top_down);
            REG_HAS_ALPHA:    prdata = APB_DATA_W'(cfg_reg.has_alpha);
            REG_ORIGIN_X:     prdata = APB_DATA_W'(cfg_reg.origin_x);
            REG_ORIGIN_Y:     prdata = APB_DATA_W'(cfg_reg.origin_y);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/bmpfb_parse.sv =====
// Byte parser: gathers pixel bytes, skips row padding, tracks position and clipping.
`timescale 1ns / 1ps
`default_nettype none

module bmpfb_parse
    import bmpfb_pkg::*;
#(
    parameter int SCREEN_WIDTH   = 800,
    parameter int SCREEN_HEIGHT  = 480,
    parameter int MAX_IMAGE_SIDE = 1024,
    parameter int CW             = (MAX_IMAGE_SIDE > 1) ? $clog2(MAX_IMAGE_SIDE) : 1,
    parameter int SXW            = ((CW > ORIGIN_W) ? CW : ORIGIN_W) + 1
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire cfg_t           cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     data_byte,
    output logic                pix_valid,
    input  wire logic           pix_take,
    output logic [SXW-1:0]      pix_sx,
    output logic [SXW-1:0]      pix_sy,
    output logic                pix_clip,
    output logic                pix_last,
    output logic [COLOR_W-1:0]  pix_color
);

    localparam int WW = CW + 1;

    logic [1:0]         phase_reg,   phase_next;
    logic [23:0]        partial_reg, partial_next;
    logic [CW-1:0]      col_reg,     col_next;
    logic [CW-1:0]      row_reg,     row_next;
    logic [1:0]         pad_reg,     pad_next;
    logic               pvalid_reg,  pvalid_next;
    logic [SXW-1:0]     sx_reg, sy_reg;
    logic               clip_reg, last_reg;
    logic [COLOR_W-1:0] color_reg;

    logic               accept;
    logic               done;
    logic               emit;
    logic [31:0]        w32, h32;
    logic [WW-1:0]      w, h;
    logic [CW-1:0]      img_y;
    logic [SXW-1:0]     sx, sy;
    logic               clip;
    logic               row_end, img_end;
    logic [COLOR_W-1:0] color;

    assign in_ready  = !pvalid_reg || pix_take;
    assign accept    = in_valid && in_ready;

    // Clamp the sizes to 1..MAX_IMAGE_SIDE.
    always_comb
    begin
        if (cfg.image_width == '0)
            w32 = 32'd1;
        else if (32'(cfg.image_width) > 32'(MAX_IMAGE_SIDE))
            w32 = 32'(MAX_IMAGE_SIDE);
        else
            w32 = 32'(cfg.image_width);
        if (cfg.image_height == '0)
            h32 = 32'd1;
        else if (32'(cfg.image_height) > 32'(MAX_IMAGE_SIDE))
            h32 = 32'(MAX_IMAGE_SIDE);
        else
            h32 = 32'(cfg.image_height);
    end

    assign w = WW'(w32);
    assign h = WW'(h32);

    assign done  = cfg.has_alpha ? (phase_reg == 2'd3) : phase_reg[1];
    assign color = cfg.has_alpha ? {data_byte, partial_reg}
                                 : {8'h00, data_byte, partial_reg[15:0]};

    // Bottom-up rows count down from the image's last row.
    always_comb
    begin
        if (cfg.top_down)
            img_y = row_reg;
        else if ({1'b0, row_reg} >= h)
            img_y = '0;
        else
            img_y = CW'(h - WW'(1) - {1'b0, row_reg});
    end

    assign sx      = SXW'(cfg.origin_x) + SXW'(col_reg);
    assign sy      = SXW'(cfg.origin_y) + SXW'(img_y);
    assign clip    = (32'(sx) >= 32'(SCREEN_WIDTH)) || (32'(sy) >= 32'(SCREEN_HEIGHT));
    assign row_end = ({1'b0, col_reg} + WW'(1)) >= w;
    assign img_end = ({1'b0, row_reg} + WW'(1)) >= h;
    assign emit    = accept && (pad_reg == 2'd0) && done;

    always_comb
    begin
        phase_next   = phase_reg;
        partial_next = partial_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        pad_next     = pad_reg;
        if (accept)
        begin
            if (pad_reg != 2'd0)
            begin
                // Drop a padding byte.
                pad_next = pad_reg - 2'd1;
            end
            else if (!done)
            begin
                case (phase_reg)
                    2'd0:    partial_next[7:0]   = data_byte;
                    2'd1:    partial_next[15:8]  = data_byte;
                    2'd2:    partial_next[23:16] = data_byte;
                    default: partial_next = partial_reg;
                endcase
                phase_next = phase_reg + 2'd1;
            end
            else
            begin
                phase_next   = 2'd0;
                partial_next = '0;
                if (row_end)
                begin
                    // 3 bytes per pixel: pad count equals width mod 4.
                    pad_next = cfg.has_alpha ? 2'd0 : w[1:0];
                    col_next = '0;
                    row_next = img_end ? '0 : row_reg + CW'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
        end
    end

    always_comb
    begin
        if (emit)
            pvalid_next = 1'b1;
        else if (pix_take)
            pvalid_next = 1'b0;
        else
            pvalid_next = pvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            partial_reg <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            pad_reg     <= '0;
            pvalid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pad_reg     <= pad_next;
            pvalid_reg  <= pvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            sx_reg    <= sx;
            sy_reg    <= sy;
            clip_reg  <= clip;
            last_reg  <= img_end && row_end;
            color_reg <= color;
        end
    end

    assign pix_valid = pvalid_reg;
    assign pix_sx    = sx_reg;
    assign pix_sy    = sy_reg;
    assign pix_clip  = clip_reg;
    assign pix_last  = last_reg;
    assign pix_color = color_reg;

endmodule

`default_nettype wire

// ===== sv/bmpfb_out.sv =====
// Result stage: framebuffer address from screen position, output register.
`timescale 1ns / 1ps
`default_nettype none

module bmpfb_out
    import bmpfb_pkg::*;
#(
    parameter int SCREEN_WIDTH = 800,
    parameter int SXW          = 11
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pix_valid,
    output logic                      pix_take,
    input  wire logic [SXW-1:0]       pix_sx,
    input  wire logic [SXW-1:0]       pix_sy,
    input  wire logic                 pix_clip,
    input  wire logic                 pix_last,
    input  wire logic [COLOR_W-1:0]   pix_color,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [PIX_ADDR_W-1:0]     pixel_address,
    output logic [COLOR_W-1:0]        pixel_color,
    output logic                      clipped,
    output logic                      last_pixel
);

    logic                  ovalid_reg, ovalid_next;
    logic [PIX_ADDR_W-1:0] addr_reg;
    logic [COLOR_W-1:0]    color_reg;
    logic                  clip_reg, last_reg;
    logic [PIX_ADDR_W-1:0] addr;
    logic                  load;

    assign pix_take = !ovalid_reg || out_ready;
    assign load     = pix_valid && pix_take;

    // Address wraps to its 19-bit field.
    assign addr = pix_clip ? '0
                : PIX_ADDR_W'(PIX_ADDR_W'(pix_sy) * PIX_ADDR_W'(SCREEN_WIDTH)
                              + PIX_ADDR_W'(pix_sx));

    always_comb
    begin
        if (load)
            ovalid_next = 1'b1;
        else if (out_ready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else
            ovalid_reg <= ovalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg  <= addr;
            color_reg <= pix_color;
            clip_reg  <= pix_clip;
            last_reg  <= pix_last;
        end
    end

    assign out_valid     = ovalid_reg;
    assign pixel_address = addr_reg;
    assign pixel_color   = color_reg;
    assign clipped       = clip_reg;
    assign last_pixel    = last_reg;

endmodule

`default_nettype wire

// ===== sv/bmp_pixel_stream_to_framebuffer.sv =====
// Top level: BMP pixel-array byte stream to ARGB framebuffer writes.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------
//   in       | in_valid / in_ready   | data_byte
//   out      | out_valid / out_ready | pixel_address, pixel_color, clipped,
//            |                       | last_pixel
//   config   | APB psel/penable      | paddr, pwdata, prdata
//
// One byte is taken per cycle while in_ready is high; a pixel result is held in the parser
// register and then in the output register, which holds the multiplied address.
// in_ready stays high while either stage has room; with both stages full and out_ready
// low, input stalls, padding bytes included.
// Reset clears the byte phase, counters, padding count and both valid flags.
// Padding bytes and non-final pixel bytes produce no result.
`timescale 1ns / 1ps
`default_nettype none

module bmp_pixel_stream_to_framebuffer
    import bmpfb_pkg::*;
#(
    parameter int SCREEN_WIDTH   = 800,
    parameter int SCREEN_HEIGHT  = 480,
    parameter int MAX_IMAGE_SIDE = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            data_byte,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [PIX_ADDR_W-1:0]      pixel_address,
    output logic [COLOR_W-1:0]         pixel_color,
    output logic                       clipped,
    output logic                       last_pixel
);

    localparam int CW  = (MAX_IMAGE_SIDE > 1) ? $clog2(MAX_IMAGE_SIDE) : 1;
    localparam int SXW = ((CW > ORIGIN_W) ? CW : ORIGIN_W) + 1;

    cfg_t               cfg;
    logic               pix_valid;
    logic               pix_take;
    logic [SXW-1:0]     pix_sx, pix_sy;
    logic               pix_clip, pix_last;
    logic [COLOR_W-1:0] pix_color;

    bmpfb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bmpfb_parse #(
        .SCREEN_WIDTH   (SCREEN_WIDTH),
        .SCREEN_HEIGHT  (SCREEN_HEIGHT),
        .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE),
        .CW             (CW),
        .SXW            (SXW)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .pix_valid (pix_valid),
        .pix_take  (pix_take),
        .pix_sx    (pix_sx),
        .pix_sy    (pix_sy),
        .pix_clip  (pix_clip),
        .pix_last  (pix_last),
        .pix_color (pix_color)
    );

    bmpfb_out #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SXW          (SXW)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_valid     (pix_valid),
        .pix_take      (pix_take),
        .pix_sx        (pix_sx),
        .pix_sy        (pix_sy),
        .pix_clip      (pix_clip),
        .pix_last      (pix_last),
        .pix_color     (pix_color),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .clipped       (clipped),
        .last_pixel    (last_pixel)
    );

endmodule

`default_nettype wire

// ===== sv/bmpfb_checker.sv =====
// Port-level assertions for the BMP pixel streamer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bmpfb_checker
    import bmpfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [PIX_ADDR_W-1:0] pixel_address,
    input  wire logic [COLOR_W-1:0]    pixel_color,
    input  wire logic                  clipped
);

    `BMPFB_ASSERT(a_out_valid_holds, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result item dropped while stalled")
    `BMPFB_ASSERT_HOLD(a_color_holds, clk, rst_n, out_valid && !out_ready, pixel_color, "color changed while stalled")
    `BMPFB_ASSERT(a_clip_addr_zero, clk, rst_n, (out_valid && clipped) |-> (pixel_address == '0), "clipped pixel with nonzero address")
    `BMPFB_ASSERT(a_addr_on_screen, clk, rst_n, (out_valid && !clipped) |-> (32'(pixel_address) < 32'(SCREEN_WIDTH * SCREEN_HEIGHT)), "address off screen")

endmodule

bind bmp_pixel_stream_to_framebuffer bmpfb_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_bmpfb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .clipped       (clipped)
);

`default_nettype wire

// ===== test/tb_bmp_pixel_stream_to_framebuffer.sv =====
// Self-checking testbench for the BMP pixel-array streamer with a built-in pixel predictor.
`timescale 1ns / 1ps

module tb_bmp_pixel_stream_to_framebuffer;
    import bmpfb_pkg::*;

    localparam int SCREEN_W       = 800;
    localparam int SCREEN_H       = 480;
    localparam int MAX_SIDE       = 1024;
    localparam int HOLD_CYCLES    = 48;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 600;

    typedef struct packed {
        logic [PIX_ADDR_W-1:0] address;
        logic [COLOR_W-1:0]    color;
        logic                  clip;
        logic                  last;
    } pixel_t;

    typedef struct {
        bit                   is_cfg;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [31:0]          value;
        bit                   typed;
        pixel_t               want;
    } stim_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [7:0]            data_byte = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PIX_ADDR_W-1:0] pixel_address;
    logic [COLOR_W-1:0]    pixel_color;
    logic                  clipped;
    logic                  last_pixel;

    // Shadow of the block's registers and pixel assembly state
    cfg_t       cfg_shadow;
    logic [1:0] byte_idx  = '0;
    logic [23:0] color_acc = '0;
    logic [9:0] col_idx   = '0;
    logic [9:0] row_idx   = '0;
    logic [1:0] pad_left  = '0;

    pixel_t    pixel_q[$];
    stim_row_t directed_rows[$];

    int mismatches    = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 35;
    int recv_idle_pct = 60;
    bit hold_req      = 1'b0;
    bit hold_taken    = 1'b0;
    int hold_left     = 0;

    bmp_pixel_stream_to_framebuffer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .clipped       (clipped),
        .last_pixel    (last_pixel)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int clamp_side(input logic [SIDE_W-1:0] side);
        if (side < 1)
            return 1;
        if (side > MAX_SIDE)
            return MAX_SIDE;
        return side;
    endfunction

    // Advance the shadow state by one byte; return 1 when a pixel completes.
    function automatic bit predict_pixel(input logic [7:0] b, output pixel_t px);
        int w;
        int h;
        int img_y;
        int sx;
        int sy;
        int row_bytes;
        px = '0;
        w  = clamp_side(cfg_shadow.image_width);
        h  = clamp_side(cfg_shadow.image_height);
        if (pad_left != 0)
        begin
            pad_left = pad_left - 2'd1;
            return 1'b0;
        end
        if (cfg_shadow.has_alpha ? (byte_idx != 2'd3) : (byte_idx < 2'd2))
        begin
            color_acc[8*byte_idx +: 8] = b;
            byte_idx = byte_idx + 2'd1;
            return 1'b0;
        end
        // Without alpha a byte at phase 2 or 3 is the red byte
        px.color  = cfg_shadow.has_alpha ? {b, color_acc} : {8'h00, b, color_acc[15:0]};
        byte_idx  = '0;
        color_acc = '0;

        if (cfg_shadow.top_down)
            img_y = row_idx;
        else
            img_y = (row_idx >= h) ? 0 : h - 1 - row_idx;
        sx = cfg_shadow.origin_x;
        sx = sx + col_idx;
        sy = cfg_shadow.origin_y;
        sy = sy + img_y;
        px.clip    = (sx >= SCREEN_W) || (sy >= SCREEN_H);
        px.address = px.clip ? '0 : PIX_ADDR_W'(sy * SCREEN_W + sx);

        if (col_idx + 1 >= w)
        begin
            row_bytes = w * (cfg_shadow.has_alpha ? 4 : 3);
            pad_left  = 2'((4 - (row_bytes & 3)) & 3);
            col_idx   = '0;
            if (row_idx + 1 >= h)
            begin
                px.last = 1'b1;
                row_idx = '0;
            end
            else
            begin
                row_idx = row_idx + 10'd1;
            end
        end
        else
        begin
            col_idx = col_idx + 10'd1;
        end
        return 1'b1;
    endfunction

    function automatic void add_cfg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        stim_row_t r;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.value   = val;
        r.typed   = 1'b0;
        r.want    = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        stim_row_t r;
        r.is_cfg  = 1'b0;
        r.reg_idx = '0;
        r.value   = {24'h0, b};
        r.typed   = 1'b0;
        r.want    = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_pixel(input logic [7:0] b, input int addr,
                                      input logic [31:0] color, input bit clip, input bit last);
        stim_row_t r;
        r.is_cfg       = 1'b0;
        r.reg_idx      = '0;
        r.value        = {24'h0, b};
        r.typed        = 1'b1;
        r.want.address = PIX_ADDR_W'(addr);
        r.want.color   = color;
        r.want.clip    = clip;
        r.want.last    = last;
        directed_rows.push_back(r);
    endfunction

    function automatic int pick_side();
        case ($urandom_range(24))
            0:       return 0;
            1:       return MAX_SIDE;
            2:       return 2047;
            3:       return MAX_SIDE - 1;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic int pick_origin(input int screen_side);
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1023;
            2, 3:    return $urandom_range(screen_side - 1, screen_side - 20);
            default: return $urandom_range(1023);
        endcase
    endfunction

    // Leaves psel high after the access edge; the next byte lowers it.
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_IMAGE_WIDTH:  cfg_shadow.image_width  = val[SIDE_W-1:0];
            REG_IMAGE_HEIGHT: cfg_shadow.image_height = val[SIDE_W-1:0];
            REG_TOP_DOWN:     cfg_shadow.top_down     = val[0];
            REG_HAS_ALPHA:    cfg_shadow.has_alpha    = val[0];
            REG_ORIGIN_X:     cfg_shadow.origin_x     = val[ORIGIN_W-1:0];
            REG_ORIGIN_Y:     cfg_shadow.origin_y     = val[ORIGIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed, input pixel_t want);
        pixel_t px;
        psel    <= 1'b0;
        penable <= 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (predict_pixel(b, px))
            pixel_q.push_back(typed ? want : px);
    endtask

    // Drain all pixels, then let bytes still in flight finish before a register write.
    task automatic settle();
        in_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_pixel
        pixel_t want;
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (pixel_q.size() == 0)
            begin
                $error("unexpected pixel: address %0d color %h", pixel_address, pixel_color);
                mismatches++;
            end
            else
            begin
                want = pixel_q.pop_front();
                if (pixel_address !== want.address)
                begin
                    $error("pixel_address: expected %0d, got %0d", want.address, pixel_address);
                    mismatches++;
                end
                if (pixel_color !== want.color)
                begin
                    $error("pixel_color: expected %h, got %h", want.color, pixel_color);
                    mismatches++;
                end
                if (clipped !== want.clip)
                begin
                    $error("clipped: expected %0b, got %0b", want.clip, clipped);
                    mismatches++;
                end
                if (last_pixel !== want.last)
                begin
                    $error("last_pixel: expected %0b, got %0b", want.last, last_pixel);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("tb_bmp_pixel_stream_to_framebuffer failed");
        $finish;
    end

    initial
    begin
        bit     prev_cfg;
        int     phase_no;
        int     random_items;
        int     n;
        int     w;
        int     h;
        int     img_bytes;
        int     wv;
        int     hv;
        bit     ha;
        pixel_t none;

        cfg_shadow              = '0;
        cfg_shadow.image_width  = 11'd1;
        cfg_shadow.image_height = 11'd1;
        none                    = '0;

        // 1x1, 24-bit, one padding byte
        add_byte(8'h00);
        add_byte(8'hff);
        add_pixel(8'h80, 0, 32'h0080_ff00, 1'b0, 1'b1);
        add_byte(8'haa);
        // 32-bit depth, all ones
        add_cfg(REG_HAS_ALPHA, 32'd1);
        add_byte(8'hff);
        add_byte(8'hff);
        add_byte(8'hff);
        add_pixel(8'hff, 0, 32'hffff_ffff, 1'b0, 1'b1);
        // off screen to the right
        add_cfg(REG_ORIGIN_X, 32'd1023);
        add_byte(8'h11);
        add_byte(8'h22);
        add_byte(8'h33);
        add_pixel(8'h44, 0, 32'h4433_2211, 1'b1, 1'b1);
        // last word of the screen
        add_cfg(REG_ORIGIN_X, 32'd799);
        add_cfg(REG_ORIGIN_Y, 32'd479);
        add_byte(8'h01);
        add_byte(8'h02);
        add_byte(8'h03);
        add_pixel(8'h04, 383999, 32'h0403_0201, 1'b0, 1'b1);
        // sizes out of range, then depth drops mid-pixel
        add_cfg(REG_IMAGE_WIDTH, 32'd0);
        add_cfg(REG_IMAGE_HEIGHT, 32'd2047);
        add_byte(8'h55);
        add_byte(8'h66);
        add_byte(8'h77);
        add_cfg(REG_HAS_ALPHA, 32'd0);
        add_pixel(8'h88, 0, 32'h0088_6655, 1'b1, 1'b0);
        add_byte(8'h00);
        // top-down, then width shrinks mid-row
        add_cfg(REG_ORIGIN_X, 32'd0);
        add_cfg(REG_ORIGIN_Y, 32'd0);
        add_cfg(REG_IMAGE_WIDTH, 32'd3);
        add_cfg(REG_IMAGE_HEIGHT, 32'd2);
        add_cfg(REG_TOP_DOWN, 32'd1);
        add_byte(8'h12);
        add_byte(8'h34);
        add_byte(8'h56);
        add_cfg(REG_IMAGE_WIDTH, 32'd1);
        add_byte(8'h9a);
        add_byte(8'hbc);
        add_byte(8'hde);

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        prev_cfg = 1'b0;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                if (!prev_cfg)
                    settle();
                apb_write(directed_rows[i].reg_idx, directed_rows[i].value);
            end
            else
            begin
                send_byte(directed_rows[i].value[7:0], directed_rows[i].typed,
                          directed_rows[i].want);
            end
            prev_cfg = directed_rows[i].is_cfg;
        end

        phase_no     = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 35;
                recv_idle_pct = 60;
            end
            else if (random_items < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 60;
                recv_idle_pct = 35;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            settle();
            wv = pick_side();
            hv = pick_side();
            ha = $urandom_range(1);
            apb_write(REG_IMAGE_WIDTH, wv);
            apb_write(REG_IMAGE_HEIGHT, hv);
            apb_write(REG_TOP_DOWN, $urandom_range(1));
            apb_write(REG_HAS_ALPHA, ha);
            apb_write(REG_ORIGIN_X, pick_origin(SCREEN_W));
            apb_write(REG_ORIGIN_Y, pick_origin(SCREEN_H));

            // Small images run once or twice, capped at 150 bytes; large ones get a slice
            w = clamp_side(wv);
            h = clamp_side(hv);
            if (w <= 8 && h <= 8)
            begin
                img_bytes = h * (((w * (ha ? 4 : 3)) + 3) & ~3);
                n = img_bytes * $urandom_range(1, 2);
            end
            else
            begin
                n = $urandom_range(30, 60);
            end
            if (n > 150)
                n = 150;
            if (phase_no == 1)
            begin
                if (n < 80)
                    n = 80;
                hold_req = 1'b1;
            end

            repeat (n)
                send_byte($urandom_range(255), 1'b0, none);
            random_items = random_items + n;
            phase_no++;
        end

        settle();
        if (mismatches == 0)
            $display("tb_bmp_pixel_stream_to_framebuffer passed");
        else
            $display("tb_bmp_pixel_stream_to_framebuffer failed");
        $finish;
    end

endmodule
